// ----- hdl/bsll_pkg.sv -----
// Shared types and codes for the bounded singly linked list core.
// Command and status encodings, fixed port field widths.
// No dependencies.
package bsll_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;
  localparam int LEN_W    = 5;

  typedef logic [CMD_W-1:0]           cmd_t;
  typedef logic [STATUS_W-1:0]        status_t;
  typedef logic signed [WORD_W-1:0]   word_t;
  typedef logic [LEN_W-1:0]           length_t;

  localparam cmd_t CMD_INS_HEAD  = 3'd0;
  localparam cmd_t CMD_INS_TAIL  = 3'd1;
  localparam cmd_t CMD_INS_AFTER = 3'd2;
  localparam cmd_t CMD_DEL_HEAD  = 3'd3;
  localparam cmd_t CMD_DEL_TAIL  = 3'd4;
  localparam cmd_t CMD_DEL_KEY   = 3'd5;
  localparam cmd_t CMD_SEARCH    = 3'd6;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

endpackage

// ----- hdl/bsll_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the node data and node link stores. No dependencies.
module bsll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/bounded_singly_linked_list_core.sv -----
// Bounded singly linked list core: list control, free list and response register.
// Depends on bsll_pkg and two bsll_ram instances (node data, node links).
//
// Usage:
//   Requests arrive on the in_ channel (in_cmd, in_value, in_key) with valid/stall.
//   A request is taken when in_valid is high and in_stall is low; in_stall is high
//   while a request is in progress, so one request is handled at a time.
//   Each request yields exactly one response on the out_ channel: out_status,
//   out_removed_value (zero when no node was removed) and out_length (nodes after).
//   Inserts at head or tail pass through allocate and link states, with an extra
//   wait state when a freed node is reused; deletes unlink, then free. Key commands
//   and delete tail walk the list, one node read per cycle from the registered-read
//   node memories, so their time depends on the walk length. The next request is
//   taken the cycle after the response loads.
//   The response sits in an output register: while the receiver holds out_stall
//   the response holds, and the next request may be accepted and worked on; it
//   then waits in its final state until the output register frees up.
//   Reset (rst_n low, synchronous) empties the list, frees every node and drops
//   any pending response. Node memories need no clearing: fresh nodes come from
//   a fill counter, recycled nodes from a free list linked through the link store.
module bounded_singly_linked_list_core #(
  parameter int POOL_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bsll_pkg::cmd_t    in_cmd,
  input  bsll_pkg::word_t   in_value,
  input  bsll_pkg::word_t   in_key,
  output logic              out_valid,
  input  logic              out_stall,
  output bsll_pkg::status_t out_status,
  output bsll_pkg::word_t   out_removed_value,
  output bsll_pkg::length_t out_length
);

  import bsll_pkg::*;

  // Pointer width covers the null code POOL_DEPTH; address width covers real nodes.
  localparam int IW = $clog2(POOL_DEPTH + 1);
  localparam int AW = $clog2(POOL_DEPTH);
  // Stored data width: the port carries at most WORD_W bits.
  localparam int SW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam logic [IW-1:0] NIL = IW'(POOL_DEPTH);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_WALK       = 4'd2;
  localparam logic [3:0] S_ALLOC      = 4'd3;
  localparam logic [3:0] S_ALLOC_WAIT = 4'd4;
  localparam logic [3:0] S_LINK1      = 4'd5;
  localparam logic [3:0] S_LINK2      = 4'd6;
  localparam logic [3:0] S_UNLINK     = 4'd7;
  localparam logic [3:0] S_FREE       = 4'd8;
  localparam logic [3:0] S_RESP       = 4'd9;

  // Control state (reset).
  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] fhead_r, fhead_nxt;   // free list head
  logic [IW-1:0] fill_r, fill_nxt;     // nodes ever handed out from the fresh pool
  logic          out_valid_r, out_valid_nxt;

  // Request context and payload (no reset).
  cmd_t          cmd_r, cmd_nxt;
  logic [SW-1:0] val_r, val_nxt;
  logic [SW-1:0] key_r, key_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] cnext_r, cnext_nxt;
  logic [IW-1:0] new_r, new_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  status_t       status_r, status_nxt;
  status_t       out_status_r, out_status_nxt;
  word_t         out_removed_r, out_removed_nxt;
  length_t       out_length_r, out_length_nxt;

  // Memory ports.
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] rd_next;
  logic [SW-1:0] rd_val;
  logic          nwe, vwe;
  logic [AW-1:0] nwaddr, vwaddr;
  logic [IW-1:0] nwdata;
  logic [SW-1:0] vwdata;

  logic                 hit;
  logic                 full;
  logic [IW+LEN_W-1:0]  count_ext;
  logic [SW+WORD_W-1:0] rem_ext;

  bsll_ram #(.WIDTH(IW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk   (clk),
    .we    (nwe),
    .waddr (nwaddr),
    .wdata (nwdata),
    .raddr (rd_addr),
    .rdata (rd_next)
  );

  bsll_ram #(.WIDTH(SW), .DEPTH(POOL_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (vwdata),
    .raddr (rd_addr),
    .rdata (rd_val)
  );

  assign full      = (count_r == NIL);
  assign count_ext = {{LEN_W{1'b0}}, count_r};
  assign rem_ext   = {{WORD_W{1'b0}}, rem_r};

  // Walk match: delete head stops at once, delete tail at the last node,
  // key commands at the first node holding the key.
  always_comb begin
    case (cmd_r)
      CMD_DEL_HEAD: hit = 1'b1;
      CMD_DEL_TAIL: hit = (rd_next == NIL);
      default:      hit = (rd_val == key_r);
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    fhead_nxt       = fhead_r;
    fill_nxt        = fill_r;
    cmd_nxt         = cmd_r;
    val_nxt         = val_r;
    key_nxt         = key_r;
    cur_nxt         = cur_r;
    prev_nxt        = prev_r;
    cnext_nxt       = cnext_r;
    new_nxt         = new_r;
    rem_nxt         = rem_r;
    status_nxt      = status_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_length_nxt  = out_length_r;
    out_valid_nxt   = out_valid_r && out_stall;
    rd_addr         = head_r[AW-1:0];
    nwe             = 1'b0;
    nwaddr          = cur_r[AW-1:0];
    nwdata          = fhead_r;
    vwe             = 1'b0;
    vwaddr          = new_r[AW-1:0];
    vwdata          = val_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          val_nxt   = in_value[SW-1:0];
          key_nxt   = in_key[SW-1:0];
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = ST_OK;
        rem_nxt    = '0;
        prev_nxt   = NIL;
        cur_nxt    = head_r;
        rd_addr    = head_r[AW-1:0];
        if (cmd_r == CMD_INS_HEAD || cmd_r == CMD_INS_TAIL) begin
          if (full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_ALLOC;
          end
        end else if (cmd_r inside {[CMD_INS_AFTER:CMD_SEARCH]}) begin
          if (head_r == NIL) begin
            status_nxt = ST_EMPTY;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_WALK;
          end
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_WALK: begin
        // Memory output holds the data and link of cur_r.
        if (hit) begin
          cnext_nxt = rd_next;
          case (cmd_r)
            CMD_SEARCH: state_nxt = S_RESP;
            CMD_INS_AFTER: begin
              if (full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            default: begin
              rem_nxt   = rd_val;
              state_nxt = S_UNLINK;
            end
          endcase
        end else if (rd_next == NIL) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_RESP;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = rd_next;
          rd_addr  = rd_next[AW-1:0];
        end
      end

      S_ALLOC: begin
        // Recycle from the free list first, else take a fresh node.
        if (fhead_r != NIL) begin
          new_nxt   = fhead_r;
          rd_addr   = fhead_r[AW-1:0];
          state_nxt = S_ALLOC_WAIT;
        end else begin
          new_nxt   = fill_r;
          fill_nxt  = fill_r + IW'(1);
          state_nxt = S_LINK1;
        end
      end

      S_ALLOC_WAIT: begin
        fhead_nxt = rd_next;
        state_nxt = S_LINK1;
      end

      S_LINK1: begin
        vwe       = 1'b1;
        vwaddr    = new_r[AW-1:0];
        vwdata    = val_r;
        nwe       = 1'b1;
        nwaddr    = new_r[AW-1:0];
        count_nxt = count_r + IW'(1);
        if (head_r == NIL) begin
          nwdata    = NIL;
          head_nxt  = new_r;
          tail_nxt  = new_r;
          state_nxt = S_RESP;
        end else if (cmd_r == CMD_INS_HEAD) begin
          nwdata    = head_r;
          head_nxt  = new_r;
          state_nxt = S_RESP;
        end else if (cmd_r == CMD_INS_TAIL) begin
          nwdata    = NIL;
          cur_nxt   = tail_r;
          tail_nxt  = new_r;
          state_nxt = S_LINK2;
        end else begin
          nwdata = cnext_r;
          if (tail_r == cur_r) begin
            tail_nxt = new_r;
          end
          state_nxt = S_LINK2;
        end
      end

      S_LINK2: begin
        nwe       = 1'b1;
        nwaddr    = cur_r[AW-1:0];
        nwdata    = new_r;
        state_nxt = S_RESP;
      end

      S_UNLINK: begin
        if (prev_r != NIL) begin
          nwe    = 1'b1;
          nwaddr = prev_r[AW-1:0];
          nwdata = cnext_r;
        end else begin
          head_nxt = cnext_r;
        end
        if (tail_r == cur_r) begin
          tail_nxt = prev_r;
        end
        state_nxt = S_FREE;
      end

      S_FREE: begin
        // Push the removed node onto the free list.
        nwe       = 1'b1;
        nwaddr    = cur_r[AW-1:0];
        nwdata    = fhead_r;
        fhead_nxt = cur_r;
        count_nxt = count_r - IW'(1);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_removed_nxt = rem_ext[WORD_W-1:0];
          out_length_nxt  = count_ext[LEN_W-1:0];
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      count_r     <= '0;
      fhead_r     <= NIL;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fhead_r     <= fhead_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    val_r         <= val_nxt;
    key_r         <= key_nxt;
    cur_r         <= cur_nxt;
    prev_r        <= prev_nxt;
    cnext_r       <= cnext_nxt;
    new_r         <= new_nxt;
    rem_r         <= rem_nxt;
    status_r      <= status_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_length_r  <= out_length_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_length        = out_length_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NIL)
    else $error("node count above pool depth");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((head_r == NIL) == (count_r == '0)))
    else $error("head pointer and node count disagree");

  a_tail_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((tail_r == NIL) == (head_r == NIL)))
    else $error("tail pointer and head pointer disagree");

  a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (cur_r != NIL))
    else $error("list walk on null node");

  a_fresh_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && fhead_r == NIL && count_r != NIL) |-> (fill_r != NIL))
    else $error("free nodes lost");

  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && (!out_valid_r || !out_stall)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("response not loaded");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bounded_singly_linked_list_core: directed table, then random
// grow/shrink/churn phases; responses checked against typed rows or a list predictor.
// Depends on bsll_pkg and the core RTL.
module testbench;
  import bsll_pkg::*;

  localparam int POOL_DEPTH   = 16;
  localparam int NIL          = POOL_DEPTH;
  localparam int RANDOM_ITEMS = 410;
  localparam int MAX_ROWS     = 32;
  localparam int CYCLE_LIMIT  = 200000;
  // Longest request in the core walks the whole list; leave some slack on top.
  localparam int SETTLE_CYCLES = POOL_DEPTH + 12;

  // Code 7 is not decoded by the core and must act as a no-op.
  localparam cmd_t CMD_UNUSED = 3'd7;

  typedef struct packed {
    status_t status;
    word_t   removed;
    length_t length;
  } response_t;

  typedef struct packed {
    cmd_t      cmd;
    word_t     value;
    word_t     key;
    bit        typed;
    response_t want;
  } stim_row_t;

  typedef enum {GROW, SHRINK, CHURN} phase_t;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  cmd_t    in_cmd    = CMD_INS_HEAD;
  word_t   in_value  = '0;
  word_t   in_key    = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  status_t out_status;
  word_t   out_removed_value;
  length_t out_length;

  bounded_singly_linked_list_core #(
    .POOL_DEPTH(POOL_DEPTH),
    .DATA_WIDTH(32)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_length       (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // List predictor: a node pool with a free map, head/tail links and a length.
  // Slot numbering need not match the core; only values and order are visible.
  // ---------------------------------------------------------------------------
  word_t slot_data [POOL_DEPTH];
  int    slot_next [POOL_DEPTH];
  bit    slot_free [POOL_DEPTH];
  int    list_head;
  int    list_tail;
  int    list_len;

  response_t pending_responses [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;

  function automatic int grab_slot();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (slot_free[i]) begin
        slot_free[i] = 1'b0;
        return i;
      end
    end
    return NIL;
  endfunction

  // Return the first node holding key; prev gets its predecessor (NIL at head).
  function automatic int find_match(word_t key, output int prev);
    int p;
    int c;
    int hops;
    p = NIL;
    c = list_head;
    hops = 0;
    prev = NIL;
    while (c != NIL && hops < POOL_DEPTH) begin
      if (slot_data[c] == key) begin
        prev = p;
        return c;
      end
      p = c;
      c = slot_next[c];
      hops++;
    end
    return NIL;
  endfunction

  function automatic word_t unlink_slot(int c, int p);
    if (p != NIL) begin
      slot_next[p] = slot_next[c];
    end else begin
      list_head = slot_next[c];
    end
    if (list_tail == c) list_tail = p;
    slot_free[c] = 1'b1;
    if (list_len > 0) list_len--;
    return slot_data[c];
  endfunction

  // Run one command on the predicted list and return the response it must give.
  function automatic response_t apply_list_command(cmd_t cmd, word_t value, word_t key);
    response_t r;
    int n;
    int c;
    int p;
    int hops;
    r.status  = ST_OK;
    r.removed = '0;
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        n = grab_slot();
        if (n == NIL) begin
          r.status = ST_FULL;
        end else begin
          slot_data[n] = value;
          if (list_head == NIL) begin
            // An insert at either end of an empty list makes the node head and tail.
            slot_next[n] = NIL;
            list_head = n;
            list_tail = n;
          end else if (cmd == CMD_INS_HEAD) begin
            slot_next[n] = list_head;
            list_head = n;
          end else begin
            slot_next[n] = NIL;
            slot_next[list_tail] = n;
            list_tail = n;
          end
          list_len++;
        end
      end
      CMD_INS_AFTER: begin
        // Empty and missing-key checks win over the full check.
        c = find_match(key, p);
        if (list_head == NIL) begin
          r.status = ST_EMPTY;
        end else if (c == NIL) begin
          r.status = ST_NOTFOUND;
        end else begin
          n = grab_slot();
          if (n == NIL) begin
            r.status = ST_FULL;
          end else begin
            slot_data[n] = value;
            slot_next[n] = slot_next[c];
            slot_next[c] = n;
            if (list_tail == c) list_tail = n;
            list_len++;
          end
        end
      end
      CMD_DEL_HEAD: begin
        if (list_head == NIL) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed = unlink_slot(list_head, NIL);
        end
      end
      CMD_DEL_TAIL: begin
        if (list_head == NIL) begin
          r.status = ST_EMPTY;
        end else begin
          p = NIL;
          c = list_head;
          hops = 0;
          while (slot_next[c] != NIL && hops < POOL_DEPTH) begin
            p = c;
            c = slot_next[c];
            hops++;
          end
          r.removed = unlink_slot(c, p);
        end
      end
      CMD_DEL_KEY: begin
        c = find_match(key, p);
        if (list_head == NIL) begin
          r.status = ST_EMPTY;
        end else if (c == NIL) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.removed = unlink_slot(c, p);
        end
      end
      CMD_SEARCH: begin
        c = find_match(key, p);
        if (list_head == NIL) begin
          r.status = ST_EMPTY;
        end else if (c == NIL) begin
          r.status = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase
    r.length = length_t'(list_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Often a few small values so that keys repeat, plus the extremes and full-range words.
  function automatic word_t pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return word_t'($urandom_range(7)) - 4;
    if (roll < 60) begin
      case ($urandom_range(3))
        0: return word_t'(32'h8000_0000);
        1: return word_t'(32'h7FFF_FFFF);
        2: return word_t'(32'hFFFF_FFFF);
        default: return '0;
      endcase
    end
    return word_t'($urandom);
  endfunction

  // Keys hit a node already in the list most of the time, so that walks get deep.
  function automatic word_t pick_key();
    int c;
    int hops;
    if (list_head == NIL || $urandom_range(99) >= 60) return pick_value();
    c = list_head;
    hops = $urandom_range(list_len - 1);
    repeat (hops) c = slot_next[c];
    return slot_data[c];
  endfunction

  function automatic cmd_t pick_command(phase_t phase);
    int insert_share;
    if ($urandom_range(99) < 2) return CMD_UNUSED;
    insert_share = (phase == GROW) ? 75 : (phase == SHRINK) ? 20 : 45;
    if ($urandom_range(99) < insert_share) begin
      case ($urandom_range(2))
        0: return CMD_INS_HEAD;
        1: return CMD_INS_TAIL;
        default: return CMD_INS_AFTER;
      endcase
    end
    case ($urandom_range(3))
      0: return CMD_DEL_HEAD;
      1: return CMD_DEL_TAIL;
      2: return CMD_DEL_KEY;
      default: return CMD_SEARCH;
    endcase
  endfunction

  // Drive one request, hold it until accepted, then log the response it owes.
  // A typed row supplies its own expectation; the predictor still runs to track state.
  task automatic send_request(cmd_t cmd, word_t value, word_t key, bit typed,
                              response_t typed_resp);
    response_t predicted;
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    in_key   <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_list_command(cmd, value, key);
    pending_responses.push_back(typed ? typed_resp : predicted);
  endtask

  // Hold off new requests until every outstanding response has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t directed_rows [MAX_ROWS];
  int        row_count = 0;

  task automatic add_row(cmd_t cmd, word_t value, word_t key, bit typed,
                         status_t status = ST_OK, word_t removed = '0, length_t length = '0);
    directed_rows[row_count].cmd          = cmd;
    directed_rows[row_count].value        = value;
    directed_rows[row_count].key          = key;
    directed_rows[row_count].typed        = typed;
    directed_rows[row_count].want.status  = status;
    directed_rows[row_count].want.removed = removed;
    directed_rows[row_count].want.length  = length;
    row_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Response checker and receiver-side backpressure
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    response_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response: status %0d removed %0d length %0d",
                                  out_status, out_removed_value, out_length));
      end else begin
        want = pending_responses.pop_front();
        if (out_status !== want.status || out_removed_value !== want.removed ||
            out_length !== want.length) begin
          report_mismatch($sformatf(
            "response mismatch (expected/actual): status %0d/%0d removed %0d/%0d length %0d/%0d",
            want.status, out_status, want.removed, out_removed_value,
            want.length, out_length));
        end
      end
    end
    // Stall the response side now and then, except during the steady window.
    out_stall <= rst_n && !no_idle && ($urandom_range(99) < 6);
  end

  // Watchdog: a hung handshake or a lost response ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    phase_t phase;
    int     issued;
    int     steps;
    int     extra;

    // Mirror the reset state: all slots free, list empty.
    for (int i = 0; i < POOL_DEPTH; i++) begin
      slot_data[i] = '0;
      slot_next[i] = NIL;
      slot_free[i] = 1'b1;
    end
    list_head = NIL;
    list_tail = NIL;
    list_len  = 0;

    // Empty-list behavior of every delete and key command, and the no-op code.
    add_row(CMD_DEL_HEAD,  '0, '0, 1'b1, ST_EMPTY, '0, 0);
    add_row(CMD_DEL_TAIL,  '0, '0, 1'b1, ST_EMPTY, '0, 0);
    add_row(CMD_DEL_KEY,   '0, '0, 1'b1, ST_EMPTY, '0, 0);
    add_row(CMD_SEARCH,    '0, '0, 1'b1, ST_EMPTY, '0, 0);
    add_row(CMD_INS_AFTER, 1,  '0, 1'b1, ST_EMPTY, '0, 0);
    add_row(CMD_UNUSED,    '0, '0, 1'b1, ST_OK,    '0, 0);
    // Tail insert on an empty list becomes the head; then the data extremes.
    add_row(CMD_INS_TAIL,  32'h7FFF_FFFF, '0, 1'b1, ST_OK, '0, 1);
    add_row(CMD_INS_HEAD,  32'h8000_0000, '0, 1'b1, ST_OK, '0, 2);
    add_row(CMD_SEARCH,    '0, 32'h8000_0000, 1'b1, ST_OK, '0, 2);
    // Missing keys: not found, and nothing is freed or added.
    add_row(CMD_SEARCH,    '0, 32'hFFFF_FFFF, 1'b1, ST_NOTFOUND, '0, 2);
    add_row(CMD_INS_AFTER, '0, 32'hFFFF_FFFF, 1'b1, ST_NOTFOUND, '0, 2);
    add_row(CMD_DEL_KEY,   '0, '0,            1'b1, ST_NOTFOUND, '0, 2);
    // Insert after the tail must move the tail pointer.
    add_row(CMD_INS_AFTER, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_row(CMD_INS_TAIL,  '0, '0, 1'b0);
    add_row(CMD_UNUSED,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_row(CMD_DEL_TAIL,  '0, '0, 1'b0);
    add_row(CMD_DEL_TAIL,  '0, '0, 1'b0);
    add_row(CMD_DEL_KEY,   '0, 32'h8000_0000, 1'b0);
    add_row(CMD_DEL_HEAD,  '0, '0, 1'b0);
    // Duplicate values: delete by key takes the first match only.
    add_row(CMD_INS_HEAD,  5, '0, 1'b0);
    add_row(CMD_INS_TAIL,  5, '0, 1'b0);
    add_row(CMD_INS_AFTER, 9, 5,  1'b0);
    add_row(CMD_DEL_KEY,   '0, 5, 1'b0);
    add_row(CMD_DEL_TAIL,  '0, '0, 1'b0);
    add_row(CMD_DEL_TAIL,  '0, '0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < row_count; i++) begin
      send_request(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].key,
                   directed_rows[i].typed, directed_rows[i].want);
    end

    // Random phases: grow until full and keep pushing for a few requests, shrink until
    // empty and a few more, or churn for a while. The first phase is a grow phase.
    phase  = GROW;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      steps = 0;
      extra = $urandom_range(2, 6);
      while (issued < RANDOM_ITEMS && steps < 80 && extra > 0) begin
        no_idle = (issued >= 150 && issued < 260);
        if (issued % 130 == 129) wait_for_drain();
        send_request(pick_command(phase), pick_value(), pick_key(), 1'b0, '0);
        issued++;
        steps++;
        if ((phase == GROW && list_len == POOL_DEPTH) || (phase == SHRINK && list_len == 0) ||
            (phase == CHURN && steps >= 30)) begin
          extra--;
        end
      end
      phase = phase_t'($urandom_range(2));
    end
    no_idle = 1'b0;

    // Drain outstanding responses, then give stray ones time to show up.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bsll_pkg.sv
hdl/bsll_ram.sv
hdl/bounded_singly_linked_list_core.sv
test/testbench.sv
